// ----- hdl/tkss_pkg.sv -----
// Package for the top-k score selector: field widths, the slot entry type,
// the per-cell control struct and the kept-count clamp function.
// Depends on nothing; every other file of the block imports it.
package tkss_pkg;

	localparam int IDX_W      = 16;
	localparam int SCORE_W    = 32;
	localparam int CNT_W      = 5;
	localparam int RANK_W     = 4;
	localparam int READ_LIMIT = 16;
	localparam int SLOT_COUNT_DEF = 16;
	localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(10);

	// One slot of the ranked list.
	typedef struct packed {
		logic               valid;
		logic [IDX_W-1:0]   idx;
		logic [SCORE_W-1:0] score;
	} slot_t;

	// Per-cell controls, driven by the top level for each cycle.
	typedef struct packed {
		logic ins;      // an offered pair is broadcast and this cell is inside the kept range
		logic shift_up; // readout: take the entry of the lower neighbor
		logic clr;      // empty this slot
	} cell_ctl_t;

	// Clamp a written count into the range 1 .. limit.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] value,
			input logic [CNT_W-1:0] limit);
		logic [CNT_W-1:0] k;
		k = (value == '0) ? CNT_W'(1) : value;
		if (k > limit) begin
			k = limit;
		end
		return k;
	endfunction

endpackage

// ----- hdl/tkss_cell.sv -----
// One slot cell of the insertion chain: holds an entry, compares it with the
// broadcast pair and hands its entry down (insert) or up (readout).
// Depends on tkss_pkg.
module tkss_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tkss_pkg::cell_ctl_t ctl,
	input  tkss_pkg::slot_t     new_ent,
	input  logic                prev_taken,
	input  tkss_pkg::slot_t     upper_ent,
	input  tkss_pkg::slot_t     lower_ent,
	output tkss_pkg::slot_t     ent,
	output logic                taken
);
	import tkss_pkg::*;

	slot_t ent_q;
	slot_t ent_d;

	// The list is descending, so the cells that beat their entry form a tail
	// of the kept range; the first of them takes the new pair.
	assign taken = ctl.ins && (new_ent.score > ent_q.score);
	assign ent   = ent_q;

	always_comb begin
		ent_d = ent_q;
		priority if (ctl.clr) begin
			ent_d = '0;
		end else if (ctl.shift_up) begin
			ent_d = lower_ent;
		end else if (ctl.ins && prev_taken) begin
			ent_d = upper_ent;
		end else if (taken) begin
			ent_d = new_ent;
		end else begin
			ent_d = ent_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

// ----- hdl/top_k_score_selector.sv -----
// Top level of the top-k score selector: handshakes, kept-count register,
// readout sequencer, output register and the chain of slot cells.
// Depends on tkss_pkg and tkss_cell.
//
// Usage: each input transaction on s_* offers one (document index, score)
// pair. The pair is compared against all kept slots in the same cycle and
// inserted in rank order, so one pair is taken every clock while the block
// is collecting. A pair whose score does not beat a slot is dropped; a tie
// never displaces an earlier entry, and a score of zero never enters.
// When the transaction carries s_tlast, the pair is inserted and then the
// block reads the list out: one output transaction per kept slot, rank 0
// first, m_tlast on the last one. Once the last pair is taken, the block
// enters the readout; each step loads rank 0 into the output register and
// shifts the chain toward rank 0, filling with empty slots, one result per
// cycle while m_tready is high, so the list is clear when it ends. s_tready
// is low only during the readout. If the receiver stalls, the current
// result waits in the output register and the chain holds. keep_count is
// to be written on the cfg channel only while idle; the block itself does
// not enforce it. Slots at and beyond the new count are emptied. Reset
// empties every slot and sets keep_count to 10, clamped to KEPT_LIM.
module top_k_score_selector #(
	parameter int SLOT_COUNT = tkss_pkg::SLOT_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input stream.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [47:0]                s_tdata,  // doc_index [15:0], doc_score [47:16]
	input  logic                       s_tlast,  // end_of_set
	// Result stream.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [55:0]                m_tdata,  // rank [3:0], best_index [19:4],
	                                             // best_score [51:20], zero [55:52]
	output logic [0:0]                 m_tuser,  // slot_filled
	output logic                       m_tlast,  // final_result
	// Configuration: keep_count.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tkss_pkg::CNT_W-1:0] cfg_data
);
	import tkss_pkg::*;

	localparam logic [CNT_W-1:0] KEPT_LIM =
		CNT_W'((SLOT_COUNT < READ_LIMIT) ? SLOT_COUNT : READ_LIMIT);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic              state_q;
	logic [CNT_W-1:0]  eff_q;
	logic [RANK_W-1:0] rank_q;

	logic              out_valid_q;
	logic [RANK_W-1:0] out_rank_q;
	slot_t             out_ent_q;
	logic              out_last_q;

	logic             s_acc;
	logic             cfg_acc;
	logic             rd_step;
	logic             rd_last;
	logic [CNT_W-1:0] new_eff;
	slot_t            new_ent;

	slot_t           ent   [SLOT_COUNT];
	logic            taken [SLOT_COUNT];
	cell_ctl_t       ctl   [SLOT_COUNT];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign new_eff   = eff_count(cfg_data, KEPT_LIM);

	assign new_ent.valid = 1'b1;
	assign new_ent.idx   = s_tdata[15:0];
	assign new_ent.score = s_tdata[47:16];

	// One readout step moves rank 0 into the output register and shifts the
	// chain up by one place.
	assign rd_step = (state_q == ST_READ) && (!out_valid_q || m_tready);
	assign rd_last = (({1'b0, rank_q} + CNT_W'(1)) == eff_q);

	// The chain of slot cells.
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		slot_t upper;
		slot_t lower;
		logic  prev;

		assign ctl[i].ins      = s_acc && (i < int'(eff_q));
		assign ctl[i].shift_up = rd_step;
		assign ctl[i].clr      = cfg_acc && (i >= int'(new_eff));

		if (i == 0) begin : g_head
			assign upper = '0;
			assign prev  = 1'b0;
		end else begin : g_body
			assign upper = ent[i-1];
			assign prev  = taken[i-1];
		end

		if (i == SLOT_COUNT - 1) begin : g_tail
			assign lower = '0;
		end else begin : g_mid
			assign lower = ent[i+1];
		end

		tkss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.new_ent    (new_ent),
			.prev_taken (prev),
			.upper_ent  (upper),
			.lower_ent  (lower),
			.ent        (ent[i]),
			.taken      (taken[i])
		);
	end

	// Sequencer and keep_count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eff_q   <= eff_count(KEEP_RESET, KEPT_LIM);
			rank_q  <= '0;
		end else begin
			if (cfg_acc) begin
				eff_q <= new_eff;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tlast) begin
						state_q <= ST_READ;
						rank_q  <= '0;
					end
				end
				ST_READ: begin
					if (rd_step) begin
						rank_q <= rank_q + RANK_W'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_step) begin
			out_rank_q <= rank_q;
			out_ent_q  <= ent[0];
			out_last_q <= rd_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000,
		out_ent_q.valid ? out_ent_q.score : {SCORE_W{1'b0}},
		out_ent_q.valid ? out_ent_q.idx : {IDX_W{1'b0}},
		out_rank_q};
	assign m_tuser  = out_ent_q.valid;
	assign m_tlast  = out_last_q;

	// A last-flagged pair always starts a readout.
	a_read_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast) |=> (state_q == ST_READ))
		else $error("readout did not start after the last pair");

	// A readout that is not finished supplies the next result at once.
	a_read_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("readout stopped before the last rank");

	// A filled slot never carries a zero score.
	a_filled_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[51:20] != '0))
		else $error("filled slot reports a zero score");

	// Input is never taken while the readout runs.
	a_no_input_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !ctl[0].ins)
		else $error("pair inserted during readout");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the top-k score selector: directed and random sets
// of (document index, score) pairs, checked against a behavioral ranked list.
// Depends on tkss_pkg and the top_k_score_selector RTL.
module tb_top;
	import tkss_pkg::*;

	// The list never reports more than this many ranks.
	localparam int LIST_DEPTH = (SLOT_COUNT_DEF < READ_LIMIT) ? SLOT_COUNT_DEF : READ_LIMIT;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_GOAL = 405;
	localparam int REPORT_MAX = 10;

	// One expected readout transaction, in the field order of the result stream.
	typedef struct packed {
		logic [RANK_W-1:0]  rank;
		logic [IDX_W-1:0]   idx;
		logic [SCORE_W-1:0] score;
		logic               filled;
		logic               fin;
	} rank_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	// Predicted state of the ranked list and its kept-count register.
	logic [IDX_W-1:0]   list_idx [LIST_DEPTH];
	logic [SCORE_W-1:0] list_score [LIST_DEPTH];
	logic               list_full [LIST_DEPTH];
	logic [CNT_W-1:0]   keep_reg = KEEP_RESET;

	// Readout transactions predicted but not yet seen on the result stream.
	rank_entry_t readout_q [$];

	// Switches for random idling on each side; both are off in the closing part.
	bit tx_idle_on = 1'b1;
	bit rx_stall_on = 1'b1;
	int rx_hold = 0;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned pairs_sent = 0;
	int unsigned sets_done = 0;
	int unsigned results_seen = 0;
	int unsigned keep_writes = 0;

	top_k_score_selector #(
		.SLOT_COUNT(SLOT_COUNT_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hang is the only way to reach this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, readout_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// Receiver back-pressure: m_tready drops at random, in bursts of stalls.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_hold <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Effective number of kept ranks for a written count: zero acts as one, and
	// anything above the list depth acts as the depth.
	function automatic int unsigned kept_ranks(input logic [CNT_W-1:0] count);
		int unsigned k;
		k = (count == '0) ? 1 : int'(count);
		if (k > LIST_DEPTH) begin
			k = LIST_DEPTH;
		end
		return k;
	endfunction

	task automatic empty_from(input int unsigned first);
		for (int i = first; i < LIST_DEPTH; i++) begin
			list_idx[i] = '0;
			list_score[i] = '0;
			list_full[i] = 1'b0;
		end
	endtask

	// A new count empties every rank at or beyond it; ranks below keep their entries.
	task automatic apply_keep(input logic [CNT_W-1:0] count);
		keep_reg = count;
		empty_from(kept_ranks(count));
		keep_writes++;
	endtask

	// Insert one pair into the predicted list. It lands at the first kept rank
	// with a strictly lower score, so ties keep the older entry ahead and a zero
	// score never gets in. On the end of a set every kept rank is queued for
	// readout and the list is emptied.
	task automatic offer_pair(input logic [IDX_W-1:0] idx, input logic [SCORE_W-1:0] score,
			input logic eos);
		int unsigned k;
		int pos;
		rank_entry_t ent;
		k = kept_ranks(keep_reg);
		pos = -1;
		for (int i = 0; i < k; i++) begin
			if (pos < 0 && score > list_score[i]) begin
				pos = i;
			end
		end
		if (pos >= 0) begin
			for (int j = k - 1; j > pos; j--) begin
				list_idx[j] = list_idx[j-1];
				list_score[j] = list_score[j-1];
				list_full[j] = list_full[j-1];
			end
			list_idx[pos] = idx;
			list_score[pos] = score;
			list_full[pos] = 1'b1;
		end
		pairs_sent++;
		if (eos) begin
			for (int r = 0; r < k; r++) begin
				ent.rank = RANK_W'(r);
				ent.idx = list_full[r] ? list_idx[r] : '0;
				ent.score = list_full[r] ? list_score[r] : '0;
				ent.filled = list_full[r];
				ent.fin = (r + 1 == k);
				readout_q.push_back(ent);
			end
			empty_from(0);
			sets_done++;
		end
	endtask

	// Drive one pair on the input stream, with an optional idle burst in front.
	// Ready is sampled at the falling edge, where every input driven at the last
	// rising edge has settled, so the transaction completes at the next rising edge.
	task automatic send_pair(input logic [IDX_W-1:0] idx, input logic [SCORE_W-1:0] score,
			input logic eos);
		bit taken;
		cfg_valid <= 1'b0;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {score, idx};
		s_tlast <= eos;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		offer_pair(idx, score, eos);
	endtask

	// Write keep_count. The input stream is held idle while the write is pending.
	task automatic write_keep(input logic [CNT_W-1:0] count);
		bit taken;
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		apply_keep(count);
	endtask

	// Let every pending result arrive, then idle so that the block can finish
	// its clear before anything else is written.
	task automatic drain();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (readout_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Scores lean toward ties, zero and the top of the range so that the
	// insertion rules get exercised, with plenty of full-width random values.
	function automatic logic [SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h0001_0000;
			3: return 32'h8000_0000;
			4: return SCORE_W'($urandom_range(1, 16));
			default: return SCORE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_keep();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CNT_W'(1);
			2: return CNT_W'(LIST_DEPTH);
			3: return '1;
			default: return CNT_W'($urandom_range(0, 31));
		endcase
	endfunction

	// Each readout transaction is checked against the oldest prediction. The
	// check runs at the falling edge, where valid and ready already hold the
	// values that the next rising edge will see.
	always @(negedge clk) begin : result_check
		rank_entry_t want;
		rank_entry_t got;
		logic [3:0] pad;
		if (arst_n && m_tvalid && m_tready) begin
			got.rank = m_tdata[3:0];
			got.idx = m_tdata[19:4];
			got.score = m_tdata[51:20];
			got.filled = m_tuser[0];
			got.fin = m_tlast;
			pad = m_tdata[55:52];
			if (readout_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected result: rank %0d idx %h score %h filled %b last %b",
						got.rank, got.idx, got.score, got.filled, got.fin);
				end
			end else begin
				want = readout_q.pop_front();
				results_seen++;
				if (got.rank !== want.rank || got.idx !== want.idx
						|| got.score !== want.score || got.filled !== want.filled
						|| got.fin !== want.fin || pad !== 4'h0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch on result %0d: expected rank %0d idx %h score %h filled %b last %b",
							results_seen, want.rank, want.idx, want.score, want.filled, want.fin);
						$display("    actual rank %0d idx %h score %h filled %b last %b pad %h",
							got.rank, got.idx, got.score, got.filled, got.fin, pad);
					end
				end
			end
		end
	end

	// Right after reset the count is 10: a short set reads out ten ranks, most empty.
	task automatic test_reset_state();
		send_pair(16'h0001, 32'h0000_0005, 1'b0);
		send_pair(16'h0002, 32'h0000_0009, 1'b0);
		send_pair(16'h0003, 32'h0000_0007, 1'b1);
		drain();
	endtask

	// Field extremes, a zero score that must not enter, and ties at the middle
	// and at the very top of the score range.
	task automatic test_field_extremes();
		write_keep(CNT_W'(16));
		send_pair(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		send_pair(16'h0000, 32'h0000_0001, 1'b0);
		send_pair(16'h1234, 32'h0000_0000, 1'b0);
		send_pair(16'hAAAA, 32'h8000_0000, 1'b0);
		send_pair(16'h5555, 32'h8000_0000, 1'b0);
		send_pair(16'h0001, 32'hFFFF_FFFF, 1'b0);
		send_pair(16'hFFFE, 32'h7FFF_FFFF, 1'b1);
		drain();
	endtask

	// A count of zero keeps one rank. A zero score flagged last still reads the
	// list out, also when the list is empty.
	task automatic test_minimum_count();
		write_keep(CNT_W'(0));
		send_pair(16'h0010, 32'h0000_0003, 1'b0);
		send_pair(16'h0011, 32'h0000_0003, 1'b0);
		send_pair(16'h0012, 32'h0000_0000, 1'b1);
		drain();
		send_pair(16'h0013, 32'h0000_0000, 1'b1);
		drain();
		write_keep(CNT_W'(1));
		send_pair(16'h0020, 32'h0000_0002, 1'b1);
		drain();
	endtask

	// Counts above the list depth are clamped to it.
	task automatic test_count_clamp();
		write_keep(CNT_W'(31));
		send_pair(16'h0030, 32'h0001_0000, 1'b0);
		send_pair(16'h0031, 32'h0002_0000, 1'b1);
		drain();
		write_keep(CNT_W'(17));
	endtask

	// Shrinking the count in the middle of a set drops the lower ranks but keeps
	// the ones above the new count.
	task automatic test_count_rewrite();
		write_keep(CNT_W'(8));
		for (int i = 0; i < 6; i++) begin
			send_pair(IDX_W'(16'h0040 + i), SCORE_W'(32'h600 - 32'h100 * i), 1'b0);
		end
		drain();
		write_keep(CNT_W'(3));
		send_pair(16'h0047, 32'h0000_0001, 1'b1);
		drain();
	endtask

	// Random sets of random length, mostly short, with the count changed between
	// sets and now and then in the middle of one. Idling is switched per set so
	// that some sets run without gaps.
	task automatic test_random_sets();
		int unsigned set_len;
		int unsigned cut;
		while (pairs_sent < RANDOM_GOAL) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_stall_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0) begin
				write_keep(pick_keep());
			end
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
			cut = ($urandom_range(0, 5) == 0 && set_len >= 4) ? $urandom_range(1, set_len - 1) : 0;
			for (int n = 0; n < set_len; n++) begin
				if (cut != 0 && n == cut) begin
					drain();
					write_keep(pick_keep());
				end
				send_pair(IDX_W'($urandom_range(0, 65535)), pick_score(), n == set_len - 1);
			end
			drain();
		end
	endtask

	// Closing part: both sides run at full rate with no idling at all.
	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_stall_on = 1'b0;
		write_keep(CNT_W'(16));
		for (int n = 0; n < 16; n++) begin
			send_pair(IDX_W'($urandom_range(0, 65535)), pick_score(), n == 15);
		end
		drain();
		write_keep(CNT_W'(5));
		for (int n = 0; n < 12; n++) begin
			send_pair(IDX_W'($urandom_range(0, 65535)), pick_score(), n == 11);
		end
		drain();
	endtask

	initial begin
		empty_from(0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_minimum_count();
		test_count_clamp();
		test_count_rewrite();
		test_random_sets();
		test_full_rate();

		if (readout_q.size() != 0) begin
			mismatches += readout_q.size();
			$display("%0d expected results never arrived", readout_q.size());
		end
		$display("ran %0d pairs in %0d sets through %0d keep_count writes",
			pairs_sent, sets_done, keep_writes);
		$display("checked %0d ranked results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
